// ===== rtl/urldec_pkg.sv =====
// ============================================================================
// urldec_pkg: shared types and constants of the URL percent decoder
// Character codes, the pending-escape state type, the group of decoded
// bytes passed from the front end to the back end, and hex helpers.
// ============================================================================
package urldec_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Most decoded bytes that one input beat can cause.
   localparam int unsigned GROUP_MAX = 3;

   // Default number of groups held between front and back end.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Pending escape state, one-hot.
   typedef enum logic [2:0] {
      PEND_NONE  = 3'b001,
      PEND_PCT   = 3'b010,
      PEND_DIGIT = 3'b100
   } pend_state_type;

   // Decoded bytes caused by one input beat, in emission order.
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] data;
      logic [1:0]                count;
      logic                      last;
   } group_type;

   // True for 0-9, A-F and a-f.
   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Nibble value of a hex digit; a letter keeps its low bits plus nine.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = c[3:0];
      end else begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// ===== rtl/urldec_if.sv =====
// ============================================================================
// urldec_if: ready/valid channels of the URL percent decoder
// Request channel carries raw bytes, response channel carries decoded bytes.
// ============================================================================
interface urldec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urldec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       message_end;

   modport source (output valid, output out_byte, output run_end,
                   output message_end, input ready);
   modport sink   (input valid, input out_byte, input run_end,
                   input message_end, output ready);
endinterface

// ===== rtl/urldec_front.sv =====
// ============================================================================
// urldec_front: input classification and escape tracking
// Accepts one raw byte per cycle while the queue is not full, tracks a
// pending escape and builds the group of decoded bytes that the beat causes.
// ============================================================================
module urldec_front (
   input  logic                  clock,
   input  logic                  reset,
   urldec_req_if.sink            req,
   input  logic                  queue_full,
   output logic                  push_valid,
   output urldec_pkg::group_type push_entry
);
   import urldec_pkg::*;

   pend_state_type state_ff, state_in;
   logic [7:0]     digit_ff, digit_in;
   logic           accept;
   logic           b_hex;
   logic [1:0]     n;
   group_type      grp;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b_hex     = is_hex(req.in_byte);

   // Build the output group and the next escape state.
   always_comb begin
      n        = 2'd0;
      grp      = '0;
      state_in = PEND_NONE;
      digit_in = digit_ff;
      case (state_ff)
         PEND_PCT: begin
            if (b_hex) begin
               if (req.in_last) begin
                  grp.data[0] = CH_PERCENT;
                  grp.data[1] = req.in_byte;
                  n           = 2'd2;
               end else begin
                  state_in = PEND_DIGIT;
                  digit_in = req.in_byte;
               end
            end else begin
               grp.data[0] = CH_PERCENT;
               n           = 2'd1;
            end
         end
         PEND_DIGIT: begin
            if (b_hex) begin
               grp.data[0] = {hex_value(digit_ff), hex_value(req.in_byte)};
               n           = 2'd1;
            end else begin
               grp.data[0] = CH_PERCENT;
               grp.data[1] = digit_ff;
               n           = 2'd2;
            end
         end
         default: begin
         end
      endcase

      // The current byte is taken afresh unless it completed or extended
      // an escape.
      if ((state_ff == PEND_NONE) || !b_hex) begin
         if ((req.in_byte == CH_PERCENT) && !req.in_last) begin
            state_in = PEND_PCT;
         end else begin
            grp.data[n] = (req.in_byte == CH_PLUS) ? CH_SPACE : req.in_byte;
            n           = n + 2'd1;
         end
      end

      if (req.in_last) begin
         state_in = PEND_NONE;
         digit_in = '0;
      end
      grp.count = n;
      grp.last  = req.in_last;
   end

   assign push_valid = accept && (n != 2'd0);
   assign push_entry = grp;

   // Escape state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PEND_NONE;
         digit_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         digit_ff <= digit_in;
      end
   end

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.in_last |=> state_ff == PEND_NONE)
      else $error("escape state not cleared after the final beat");
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req.in_last |-> push_valid)
      else $error("final beat of a message produced no byte");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_entry.count != 2'd0)
      else $error("empty group pushed");
   a_escape_done: assert property (@(posedge clock) disable iff (reset)
      accept && (state_ff == PEND_DIGIT) && b_hex |-> push_valid &&
      (push_entry.count == 2'd1) && (state_in == PEND_NONE))
      else $error("completed escape not decoded to one byte");
`endif

endmodule

// ===== rtl/urldec_queue.sv =====
// ============================================================================
// urldec_queue: group queue between front and back end
// Small circular buffer of decoded byte groups; lets either side stall.
// ============================================================================
module urldec_queue #(
   parameter int unsigned DEPTH = urldec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  urldec_pkg::group_type push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output urldec_pkg::group_type head
);
   import urldec_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   group_type     store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;

   assign full  = (fill_ff == CW'(DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   // Pointer and fill updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Group storage, no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/urldec_back.sv =====
// ============================================================================
// urldec_back: response serializer
// Sends the bytes of the head group one beat at a time and marks the end
// of each run and of each message.
// ============================================================================
module urldec_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  urldec_pkg::group_type head,
   output logic                  pop,
   urldec_rsp_if.source          rsp
);
   import urldec_pkg::*;

   logic [1:0] pos_ff, pos_in;
   logic       at_end;
   logic       fire;

   assign at_end = (pos_ff == (head.count - 2'd1));
   assign fire   = rsp.valid && rsp.ready;
   assign pop    = fire && at_end;

   // Response beat taken from the head group.
   assign rsp.valid       = !empty;
   assign rsp.out_byte    = head.data[pos_ff];
   assign rsp.run_end     = at_end;
   assign rsp.message_end = at_end && head.last;

   always_comb begin
      pos_in = pos_ff;
      if (fire) begin
         pos_in = at_end ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/url_percent_decoder_unit.sv =====
// ============================================================================
// url_percent_decoder_unit: streaming form-urlencoded decoder
// Turns '+' into a space and '%XX' escapes into bytes, passing all else.
// ============================================================================
// Usage:
//   req carries one raw byte per beat, with in_last on the final byte of a
//   message. rsp carries decoded bytes; run_end marks the last byte caused
//   by one request beat, message_end the last byte of the message.
//   A beat that only extends an escape ('%' or its first hex digit) causes
//   no response; a broken escape is sent back literally.
// Timing:
//   The queue registers each group; a beat accepted into an empty queue
//   has its first response byte valid in the next cycle. The front end
//   takes one beat per cycle while the queue is not full; the response
//   side sends one byte per cycle while rsp.ready is high; a beat can cause
//   up to three bytes. A queue of QUEUE_DEPTH groups absorbs these bursts.
// Reset and stall:
//   Synchronous reset empties the queue and drops any pending escape.
//   While rsp.ready is low the queue fills; req.ready falls only when the
//   queue is full.
// ============================================================================
module url_percent_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = urldec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   urldec_req_if.sink   req,
   urldec_rsp_if.source rsp
);
   import urldec_pkg::*;

   logic      push_valid;
   group_type push_entry;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;
   group_type head;

   urldec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   urldec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   urldec_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (queue_empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
